// ===== design/tbfm_pkg.sv =====
// Shared types, constants and coefficient tables for the three-band FIR mixer.
// Depends on nothing; imported by every module of the block.
package tbfm_pkg;

  // Filter geometry: symmetric taps, so only the first half is stored.
  localparam int TAP_COUNT   = 51;
  localparam int HALF_TAPS   = 26;
  localparam int AGE_WIDTH   = $clog2(TAP_COUNT);
  localparam int FILL_WIDTH  = $clog2(TAP_COUNT + 1);
  localparam int HALF_WIDTH  = $clog2(HALF_TAPS);
  localparam int TABLE_WIDTH = 18;

  // Gain format and band count.
  localparam int GAIN_WIDTH = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int BAND_COUNT = 3;
  localparam int GAIN_STEPS = 2 * BAND_COUNT;
  localparam int GSTEP_WIDTH = $clog2(GAIN_STEPS);

  localparam logic signed [GAIN_WIDTH-1:0] GAIN_RESET = 16'sd4096;

  // Configuration register indexes.
  localparam int CFG_IDX_WIDTH = 2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LOW_GAIN  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MID_GAIN  = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HIGH_GAIN = 2'd2;

  typedef enum logic [1:0] {
    BAND_LOW,
    BAND_MID,
    BAND_HIGH
  } band_e;

  // Control word that travels alongside an operand pair through the MAC.
  typedef struct packed {
    logic en;    // operation present
    logic clr;   // start a fresh sum with this product
    logic hi;    // product belongs to the upper half of a split operand
    logic last;  // final product of the sum
  } mac_ctrl_t;

  // First half of each symmetric Q1.17 coefficient set, taps 0 to 25.
  localparam int LP_HALF [HALF_TAPS] = '{
    -127, -108, -68, 5, 118, 269, 434, 565, 600, 474, 142, -399, -1090,
    -1809, -2376, -2578, -2212, -1126, 741, 3322, 6426, 9747, 12908, 15519,
    17241, 17842
  };
  localparam int BP_HALF [HALF_TAPS] = '{
    11, 160, 236, -20, -390, -347, -14, -285, -1172, -1123, 503, 1607, 563,
    -137, 2466, 5421, 3085, -2656, -3339, 1360, -754, -15210, -25159, -9619,
    23963, 41728
  };
  localparam int HP_HALF [HALF_TAPS] = '{
    117, -52, -168, 15, 272, 77, -420, -281, 570, 648, -644, -1205, 529,
    1948, -85, -2832, -866, 3779, 2593, -4683, -5678, 5432, 12202, -5927,
    -41180, 71720
  };

  // Rescale a Q1.17 coefficient to the chosen width: exact when widening,
  // rounded half up when narrowing.
  function automatic int coef_scale(input int c, input int cw);
    int res;
    if (cw >= TABLE_WIDTH) begin
      res = c <<< (cw - TABLE_WIDTH);
    end else begin
      res = (c + (1 <<< (TABLE_WIDTH - cw - 1))) >>> (TABLE_WIDTH - cw);
    end
    return res;
  endfunction

  // Coefficient of one band at one half-table position.
  function automatic int coef_lookup(input band_e band, input logic [HALF_WIDTH-1:0] k,
                                     input int cw);
    int c;
    case (band)
      BAND_LOW:  c = LP_HALF[k];
      BAND_MID:  c = BP_HALF[k];
      BAND_HIGH: c = HP_HALF[k];
      default:   c = 0;
    endcase
    return coef_scale(c, cw);
  endfunction

endpackage

// ===== design/tbfm_delay_mem.sv =====
// Sample delay line held as a circular memory with two registered read ports.
// Depends on tbfm_pkg for the tap count and index widths.
module tbfm_delay_mem import tbfm_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic signed [DATA_WIDTH-1:0] wr_data_i,
  input  logic        [AGE_WIDTH-1:0]  rd_age_a_i,
  input  logic        [AGE_WIDTH-1:0]  rd_age_b_i,
  input  logic                         rd_b_en_i,
  output logic signed [DATA_WIDTH-1:0] rd_a_o,
  output logic signed [DATA_WIDTH-1:0] rd_b_o
);

  logic [DATA_WIDTH-1:0] mem_q [TAP_COUNT];
  logic [AGE_WIDTH-1:0]  newest_q;
  logic [FILL_WIDTH-1:0] fill_q;
  logic [AGE_WIDTH-1:0]  wr_addr;
  logic [AGE_WIDTH-1:0]  addr_a;
  logic [AGE_WIDTH-1:0]  addr_b;
  logic                  valid_a;
  logic                  valid_b;
  logic signed [DATA_WIDTH-1:0] rd_a_q;
  logic signed [DATA_WIDTH-1:0] rd_b_q;

  // Address of the sample that is a given number of requests old.
  function automatic logic [AGE_WIDTH-1:0] age_addr(input logic [AGE_WIDTH-1:0] newest,
                                                    input logic [AGE_WIDTH-1:0] age);
    logic [AGE_WIDTH:0] diff;
    diff = {1'b0, newest} - {1'b0, age};
    if (diff[AGE_WIDTH]) begin
      diff = diff + (AGE_WIDTH + 1)'(TAP_COUNT);
    end
    return diff[AGE_WIDTH-1:0];
  endfunction

  // Next write slot wraps round the line; entries older than the fill read as zero.
  always_comb begin
    wr_addr = (newest_q == AGE_WIDTH'(TAP_COUNT - 1)) ? '0 : newest_q + 1'b1;
    addr_a  = age_addr(newest_q, rd_age_a_i);
    addr_b  = age_addr(newest_q, rd_age_b_i);
    valid_a = FILL_WIDTH'(rd_age_a_i) < fill_q;
    valid_b = (FILL_WIDTH'(rd_age_b_i) < fill_q) && rd_b_en_i;
  end

  // Write pointer and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= AGE_WIDTH'(TAP_COUNT - 1);
      fill_q   <= '0;
    end else if (wr_en_i) begin
      newest_q <= wr_addr;
      if (fill_q != FILL_WIDTH'(TAP_COUNT)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Sample storage.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr] <= wr_data_i;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    rd_a_q <= valid_a ? signed'(mem_q[addr_a]) : '0;
    rd_b_q <= valid_b ? signed'(mem_q[addr_b]) : '0;
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// ===== design/tbfm_mac.sv =====
// Shared pre-add, multiply and accumulate unit, three register stages deep.
// Depends on tbfm_pkg for the control word type.
module tbfm_mac import tbfm_pkg::*; #(
  parameter int OPR_WIDTH = 21,
  parameter int B_WIDTH   = 18,
  parameter int ACC_WIDTH = 58,
  parameter int SPLIT     = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mac_ctrl_t                   ctrl_i,
  input  logic signed [OPR_WIDTH-1:0] a0_i,
  input  logic signed [OPR_WIDTH-1:0] a1_i,
  input  logic signed [B_WIDTH-1:0]   b_i,
  output logic signed [ACC_WIDTH-1:0] acc_o,
  output logic                        done_o
);

  localparam int SUM_W  = OPR_WIDTH + 1;
  localparam int PROD_W = SUM_W + B_WIDTH;
  localparam int EXT_W  = PROD_W + SPLIT + ACC_WIDTH;

  mac_ctrl_t                   c1_q;
  mac_ctrl_t                   c2_q;
  logic                        done_q;
  logic signed [SUM_W-1:0]     sum_q;
  logic signed [B_WIDTH-1:0]   b_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [ACC_WIDTH-1:0] acc_q;
  logic signed [EXT_W-1:0]     prod_ext;
  logic signed [ACC_WIDTH-1:0] term;
  logic signed [ACC_WIDTH-1:0] acc_d;

  // Align the product for the upper half of a split operand, then accumulate.
  always_comb begin
    prod_ext = EXT_W'(prod_q);
    if (c2_q.hi) begin
      prod_ext = prod_ext <<< SPLIT;
    end
    term  = prod_ext[ACC_WIDTH-1:0];
    acc_d = c2_q.clr ? term : acc_q + term;
  end

  // Control pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q   <= '0;
      c2_q   <= '0;
      done_q <= 1'b0;
    end else begin
      c1_q   <= ctrl_i;
      c2_q   <= c1_q;
      done_q <= c2_q.en & c2_q.last;
    end
  end

  // Data pipeline: pre-add, multiply, accumulate.
  always_ff @(posedge clk_i) begin
    sum_q  <= SUM_W'(a0_i) + SUM_W'(a1_i);
    b_q    <= b_i;
    prod_q <= PROD_W'(sum_q) * PROD_W'(b_q);
    if (c2_q.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

// ===== design/three_band_fir_audio_mixer.sv =====
// Top level of the three-band FIR mixer: sequencer, gain registers and output stage.
// Depends on tbfm_pkg, tbfm_delay_mem and tbfm_mac.
//
//   Channel  Direction  Handshake                  Payload
//   cfg      in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_ready_o    audio_in_i
//   out      out        out_valid_o / out_ready_i  audio_out_o, clipped_o
//
// The time a sample takes is set by the single multiplier: 78 tap-pair products
// (26 per band), six partial gain products and the pipeline drain between them.
// The rounded result enters the output register, and the next request is taken
// once the block is back in idle. The delay line reads as zero after reset through a
// fill count, so no clearing pass is needed. A stalled result waits in the output
// register; while it waits the block holds its finished sum. Configuration
// writes are taken in any cycle.
module three_band_fir_audio_mixer import tbfm_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0]       cfg_index_i,
  input  logic signed [GAIN_WIDTH-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] audio_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] audio_out_o,
  output logic                           clipped_o
);

  // Band sum: pair sum adds one bit, 26 terms add five.
  localparam int BAND_W  = SAMPLE_WIDTH + COEF_WIDTH + 6;
  localparam int LO_W    = BAND_W / 2;
  localparam int HI_W    = BAND_W - LO_W;
  localparam int OPR_W0  = (SAMPLE_WIDTH > HI_W) ? SAMPLE_WIDTH : HI_W;
  localparam int OPR_W   = (OPR_W0 > LO_W + 1) ? OPR_W0 : LO_W + 1;
  localparam int MUL_B_W = (COEF_WIDTH > GAIN_WIDTH) ? COEF_WIDTH : GAIN_WIDTH;
  // Gained mix needs the band width plus the gain and two bits; its width is capped at 64.
  localparam int ACC_W   = (BAND_W + GAIN_WIDTH + 2 > 64) ? 64 : BAND_W + GAIN_WIDTH + 2;
  localparam int SHIFT   = COEF_WIDTH - 1 + GAIN_FRAC;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (SHIFT - 1));
  localparam logic signed [ACC_W-1:0] SAMPLE_MAX =
    ACC_W'({1'b0, {(SAMPLE_WIDTH - 1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAMPLE_MIN = ~SAMPLE_MAX;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAPS,
    S_TAP_WAIT,
    S_GAIN,
    S_GAIN_WAIT,
    S_ROUND
  } state_e;

  state_e                         state_q;
  band_e                          band_q;
  logic [HALF_WIDTH-1:0]          k_q;
  logic [GSTEP_WIDTH-1:0]         gstep_q;
  logic [1:0]                     cap_q;
  mac_ctrl_t                      s1_ctrl_q;
  logic signed [MUL_B_W-1:0]      s1_coef_q;
  logic signed [GAIN_WIDTH-1:0]   gain_q [BAND_COUNT];
  logic signed [BAND_W-1:0]       band_sum_q [BAND_COUNT];
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] audio_out_q;
  logic                           clipped_q;

  logic                           in_accept;
  logic                           out_free;
  mac_ctrl_t                      tap_ctrl;
  logic [AGE_WIDTH-1:0]           age_b;
  logic signed [SAMPLE_WIDTH-1:0] rd_a;
  logic signed [SAMPLE_WIDTH-1:0] rd_b;
  logic signed [BAND_W-1:0]       gain_band;
  mac_ctrl_t                      mac_ctrl;
  logic signed [OPR_W-1:0]        mac_a0;
  logic signed [OPR_W-1:0]        mac_a1;
  logic signed [MUL_B_W-1:0]      mac_b;
  logic signed [ACC_W-1:0]        mac_acc;
  logic                           mac_done;
  logic signed [ACC_W-1:0]        rnd_sum;
  logic signed [ACC_W-1:0]        mix;
  logic signed [SAMPLE_WIDTH-1:0] mix_sat;
  logic                           mix_clip;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;

  // Tap step control: a fresh sum at the first pair, middle tap taken alone.
  always_comb begin
    tap_ctrl.en   = (state_q == S_TAPS);
    tap_ctrl.clr  = (k_q == '0);
    tap_ctrl.hi   = 1'b0;
    tap_ctrl.last = (k_q == HALF_WIDTH'(HALF_TAPS - 1));
    age_b         = AGE_WIDTH'(TAP_COUNT - 1) - AGE_WIDTH'(k_q);
  end

  tbfm_delay_mem #(
    .DATA_WIDTH (SAMPLE_WIDTH)
  ) u_delay (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (in_accept),
    .wr_data_i  (audio_in_i),
    .rd_age_a_i (AGE_WIDTH'(k_q)),
    .rd_age_b_i (age_b),
    .rd_b_en_i  (k_q != HALF_WIDTH'(HALF_TAPS - 1)),
    .rd_a_o     (rd_a),
    .rd_b_o     (rd_b)
  );

  // MAC operand select: sample pairs and coefficient, or a band-sum half and its gain.
  always_comb begin
    gain_band = band_sum_q[gstep_q[2:1]];
    if (state_q == S_GAIN) begin
      if (gstep_q[0]) begin
        mac_a0 = OPR_W'(signed'(gain_band[BAND_W-1:LO_W]));
      end else begin
        mac_a0 = OPR_W'(gain_band[LO_W-1:0]);
      end
      mac_a1        = '0;
      mac_b         = MUL_B_W'(gain_q[gstep_q[2:1]]);
      mac_ctrl.en   = 1'b1;
      mac_ctrl.clr  = (gstep_q == '0);
      mac_ctrl.hi   = gstep_q[0];
      mac_ctrl.last = (gstep_q == GSTEP_WIDTH'(GAIN_STEPS - 1));
    end else begin
      mac_a0   = OPR_W'(rd_a);
      mac_a1   = OPR_W'(rd_b);
      mac_b    = s1_coef_q;
      mac_ctrl = s1_ctrl_q;
    end
  end

  tbfm_mac #(
    .OPR_WIDTH (OPR_W),
    .B_WIDTH   (MUL_B_W),
    .ACC_WIDTH (ACC_W),
    .SPLIT     (LO_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a0_i   (mac_a0),
    .a1_i   (mac_a1),
    .b_i    (mac_b),
    .acc_o  (mac_acc),
    .done_o (mac_done)
  );

  // Round half up to the sample format and saturate.
  always_comb begin
    rnd_sum  = mac_acc + ROUND_HALF;
    mix      = rnd_sum >>> SHIFT;
    mix_clip = 1'b0;
    mix_sat  = mix[SAMPLE_WIDTH-1:0];
    if (mix > SAMPLE_MAX) begin
      mix_sat  = SAMPLE_MAX[SAMPLE_WIDTH-1:0];
      mix_clip = 1'b1;
    end else if (mix < SAMPLE_MIN) begin
      mix_sat  = SAMPLE_MIN[SAMPLE_WIDTH-1:0];
      mix_clip = 1'b1;
    end
  end

  // Coefficient fetch aligned with the memory read, and band sum capture.
  always_ff @(posedge clk_i) begin
    s1_coef_q <= MUL_B_W'(coef_lookup(band_q, k_q, COEF_WIDTH));
    if (mac_done && (state_q != S_GAIN_WAIT)) begin
      band_sum_q[cap_q] <= mac_acc[BAND_W-1:0];
    end
  end

  // Sequencer, gain registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      band_q      <= BAND_LOW;
      k_q         <= '0;
      gstep_q     <= '0;
      cap_q       <= '0;
      s1_ctrl_q   <= '0;
      gain_q[BAND_LOW]  <= GAIN_RESET;
      gain_q[BAND_MID]  <= GAIN_RESET;
      gain_q[BAND_HIGH] <= GAIN_RESET;
      out_valid_q <= 1'b0;
      audio_out_q <= '0;
      clipped_q   <= 1'b0;
    end else begin
      s1_ctrl_q <= tap_ctrl;

      // Gain register writes.
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_LOW_GAIN:  gain_q[BAND_LOW]  <= cfg_data_i;
          REG_MID_GAIN:  gain_q[BAND_MID]  <= cfg_data_i;
          REG_HIGH_GAIN: gain_q[BAND_HIGH] <= cfg_data_i;
          default: ;
        endcase
      end

      // Count finished band sums.
      if (mac_done && (state_q != S_GAIN_WAIT)) begin
        cap_q <= cap_q + 1'b1;
      end

      // A taken result frees the output register unless a new one replaces it.
      if (out_valid_q && out_ready_i && (state_q != S_ROUND)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_TAPS;
            band_q  <= BAND_LOW;
            k_q     <= '0;
            cap_q   <= '0;
          end
        end
        S_TAPS: begin
          if (k_q == HALF_WIDTH'(HALF_TAPS - 1)) begin
            k_q <= '0;
            if (band_q == BAND_HIGH) begin
              state_q <= S_TAP_WAIT;
            end else begin
              band_q <= band_e'(band_q + 2'd1);
            end
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_TAP_WAIT: begin
          if (cap_q == 2'(BAND_COUNT)) begin
            state_q <= S_GAIN;
            gstep_q <= '0;
          end
        end
        S_GAIN: begin
          if (gstep_q == GSTEP_WIDTH'(GAIN_STEPS - 1)) begin
            state_q <= S_GAIN_WAIT;
          end else begin
            gstep_q <= gstep_q + 1'b1;
          end
        end
        S_GAIN_WAIT: begin
          if (mac_done) begin
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            audio_out_q <= mix_sat;
            clipped_q   <= mix_clip;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign audio_out_o = audio_out_q;
  assign clipped_o   = clipped_q;

endmodule
